[hdl/jfcd_pkg.sv]
`timescale 1ns / 1ps
// jfcd_pkg: shared types and constants for the jpeg frame capture deframer
// no dependencies; imported by every module of the block

package jfcd_pkg;

  localparam int ADDR_W  = 17;
  localparam int COUNT_W = 32;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [23:0] SYNC_WORD  = 24'h015AC0;
  localparam logic [7:0]  SYNC_B0    = 8'hC0;
  localparam logic [7:0]  SYNC_B1    = 8'h5A;
  localparam logic [7:0]  SYNC_B2    = 8'h01;
  localparam logic [7:0]  FLAG_BUSY  = 8'h00;
  localparam logic [7:0]  FLAG_READY = 8'hC0;

  // header write steps: busy flag, then the three sync bytes
  localparam logic [1:0] STEP_BUSY = 2'd0;
  localparam logic [1:0] STEP_B0   = 2'd1;
  localparam logic [1:0] STEP_B1   = 2'd2;
  localparam logic [1:0] STEP_B2   = 2'd3;

  typedef struct packed {
    logic       start_req;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic               write_valid;
    logic [ADDR_W-1:0]  write_addr;
    logic [7:0]         write_data;
    logic               frame_done;
    logic               sync_error;
    logic [COUNT_W-1:0] frame_count;
    logic               last;
  } out_item_t;

  // one classified word from the front end
  typedef struct packed {
    logic               hdr;      // sync matched with memory on: four header writes
    logic               err;      // sync check failed
    logic               wr;       // stream byte write
    logic               done;     // frame complete, ready flag
    logic               done_wr;  // ready flag goes to memory
    logic [ADDR_W-1:0]  addr;
    logic [7:0]         data;
    logic [COUNT_W-1:0] count;
  } cmd_t;

endpackage

[hdl/jfcd_front.sv]
`timescale 1ns / 1ps
// jfcd_front: accepts received words, tracks the frame header and length,
// and issues one command per word; depends on jfcd_pkg

module jfcd_front import jfcd_pkg::*; #(
  parameter int REGION_BYTES = 131072,
  parameter int FIRST_READ   = 2048,
  parameter int HEADER_BYTES = 11
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  input  logic     cfg_wr_en,
  input  logic     cfg_wr_data,
  input  logic     q_full,
  output logic     push,
  output cmd_t     cmd
);

  localparam int IDX_MAX = (REGION_BYTES > FIRST_READ) ? REGION_BYTES : FIRST_READ;
  localparam int IDX_W   = $clog2(IDX_MAX + 1);
  localparam logic [31:0]      LEN_MAX   = 32'(REGION_BYTES - HEADER_BYTES - 1);
  localparam logic [IDX_W-1:0] FIRST_END = IDX_W'(FIRST_READ);
  localparam logic [IDX_W-1:0] HDR_LEN   = IDX_W'(HEADER_BYTES);
  localparam logic [IDX_W-1:0] SYNC_LAST = IDX_W'(2);
  localparam logic [IDX_W-1:0] LEN_B0    = IDX_W'(3);
  localparam logic [IDX_W-1:0] LEN_B1    = IDX_W'(4);
  localparam logic [IDX_W-1:0] LEN_B2    = IDX_W'(5);
  localparam logic [IDX_W-1:0] LEN_B3    = IDX_W'(6);

  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_SYNC    = 4'b0010,
    PH_STREAM  = 4'b0100,
    PH_DISCARD = 4'b1000
  } phase_t;

  phase_t             phase, phase_next, phase_cur;
  logic [IDX_W-1:0]   byte_index, byte_index_next, idx_cur, idx_inc;
  logic [23:0]        held_sync, held_sync_next, hs_cur;
  logic [23:0]        length_lo, length_lo_next, len_cur;
  logic [IDX_W-1:0]   frame_end, frame_end_next, fe_cur, fe_eff;
  logic [COUNT_W-1:0] frame_counter, frame_counter_next;
  logic               mem_enable;
  logic [31:0]        len_full, len_clamp;
  logic [IDX_W-1:0]   end_sum, end_calc;
  logic               accept;

  assign accept   = in_valid & ~q_full;
  assign in_stall = q_full;
  assign push     = accept;

  always_comb begin
    phase_cur = in_item.start_req ? PH_SYNC : phase;
    idx_cur   = in_item.start_req ? '0 : byte_index;
    hs_cur    = in_item.start_req ? '0 : held_sync;
    len_cur   = in_item.start_req ? '0 : length_lo;
    fe_cur    = in_item.start_req ? '0 : frame_end;
    idx_inc   = idx_cur + IDX_W'(1);

    // length field complete on the last length byte, clamped to the region
    len_full  = {in_item.rx_byte, len_cur};
    len_clamp = (len_full > LEN_MAX) ? LEN_MAX : len_full;
    end_sum   = HDR_LEN + IDX_W'(len_clamp);
    end_calc  = (end_sum < FIRST_END) ? FIRST_END : end_sum;
    fe_eff    = (idx_cur == LEN_B3) ? end_calc : fe_cur;

    phase_next         = phase_cur;
    byte_index_next    = idx_cur;
    held_sync_next     = hs_cur;
    length_lo_next     = len_cur;
    frame_end_next     = fe_cur;
    frame_counter_next = frame_counter;
    cmd                = '0;

    unique case (phase_cur)
      PH_SYNC: begin
        case (idx_cur[1:0])
          2'd0:    held_sync_next = hs_cur | {16'h0, in_item.rx_byte};
          2'd1:    held_sync_next = hs_cur | {8'h0, in_item.rx_byte, 8'h0};
          default: held_sync_next = hs_cur | {in_item.rx_byte, 16'h0};
        endcase
        byte_index_next = idx_inc;
        if (idx_cur == SYNC_LAST) begin
          if (held_sync_next == SYNC_WORD) begin
            phase_next     = PH_STREAM;
            frame_end_next = FIRST_END;
            cmd.hdr        = mem_enable;
          end else begin
            phase_next = PH_DISCARD;
            cmd.err    = 1'b1;
          end
        end
      end
      PH_STREAM: begin
        case (idx_cur)
          LEN_B0:  length_lo_next[7:0]   = in_item.rx_byte;
          LEN_B1:  length_lo_next[15:8]  = in_item.rx_byte;
          LEN_B2:  length_lo_next[23:16] = in_item.rx_byte;
          default: length_lo_next        = len_cur;
        endcase
        frame_end_next  = fe_eff;
        byte_index_next = idx_inc;
        cmd.wr          = mem_enable;
        cmd.addr        = ADDR_W'(idx_inc);
        cmd.data        = in_item.rx_byte;
        if (idx_inc >= fe_eff) begin
          frame_counter_next = frame_counter + COUNT_W'(1);
          cmd.done           = 1'b1;
          cmd.done_wr        = mem_enable;
          phase_next         = PH_IDLE;
        end
      end
      PH_DISCARD: begin
        byte_index_next = idx_inc;
        if (idx_inc >= FIRST_END) begin
          phase_next = PH_IDLE;
        end
      end
      PH_IDLE: begin
        phase_next = PH_IDLE;
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase

    cmd.count = frame_counter_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      byte_index    <= '0;
      held_sync     <= '0;
      length_lo     <= '0;
      frame_end     <= '0;
      frame_counter <= '0;
      mem_enable    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mem_enable <= cfg_wr_data;
      end
      if (accept) begin
        phase         <= phase_next;
        byte_index    <= byte_index_next;
        held_sync     <= held_sync_next;
        length_lo     <= length_lo_next;
        frame_end     <= frame_end_next;
        frame_counter <= frame_counter_next;
      end
    end
  end

endmodule

[hdl/jfcd_queue.sv]
`timescale 1ns / 1ps
// jfcd_queue: short command queue between front and back end
// depends on jfcd_pkg

module jfcd_queue import jfcd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t pop_cmd
);

  cmd_t               slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign full    = (count == Q_CNT_W'(Q_DEPTH));
  assign valid   = (count != '0);
  assign pop_cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + Q_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - Q_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

[hdl/jfcd_back.sv]
`timescale 1ns / 1ps
// jfcd_back: expands each queued command into its result words and holds
// them in the output register; depends on jfcd_pkg

module jfcd_back import jfcd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  input  cmd_t      q_cmd,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic [1:0] step;
  logic [1:0] last_step;
  logic       is_last;
  logic       load;
  out_item_t  res;

  assign load      = ~out_valid | ~out_stall;
  assign last_step = q_cmd.hdr ? STEP_B2 : ((q_cmd.wr && q_cmd.done) ? 2'd1 : 2'd0);
  assign is_last   = (step == last_step);
  assign q_pop     = load & q_valid & is_last;

  always_comb begin
    res             = '0;
    res.frame_count = q_cmd.count;
    res.last        = is_last;
    if (q_cmd.hdr) begin
      res.write_valid = 1'b1;
      res.write_addr  = ADDR_W'(step);
      unique case (step)
        STEP_BUSY: res.write_data = FLAG_BUSY;
        STEP_B0:   res.write_data = SYNC_B0;
        STEP_B1:   res.write_data = SYNC_B1;
        STEP_B2:   res.write_data = SYNC_B2;
        default:   res.write_data = FLAG_BUSY;
      endcase
    end else if (q_cmd.err) begin
      res.sync_error = 1'b1;
    end else if (q_cmd.wr && step == 2'd0) begin
      res.write_valid = 1'b1;
      res.write_addr  = q_cmd.addr;
      res.write_data  = q_cmd.data;
    end else if (q_cmd.done) begin
      res.write_valid = q_cmd.done_wr;
      res.write_data  = FLAG_READY;
      res.frame_done  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= '0;
    end else if (load) begin
      out_valid <= q_valid;
      if (q_valid) begin
        step <= is_last ? 2'd0 : step + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && q_valid) begin
      out_item <= res;
    end
  end

endmodule

[hdl/jpeg_frame_capture_deframer.sv]
`timescale 1ns / 1ps
// jpeg_frame_capture_deframer: top level, front end, command queue and back end
// depends on jfcd_pkg, jfcd_front, jfcd_queue, jfcd_back

// Takes one received frame word per cycle and turns it into shared-memory
// writes. A word is accepted in any cycle in which the four-entry command
// queue has room; the queue fills only when the output side falls behind.
// Most words make a single result word. With memory enabled, the third sync
// byte of a good header makes four (busy flag and the three sync bytes) and
// the final frame byte makes two (the byte and the ready flag). The back end
// issues one result word per cycle while the output is not stalled, so the
// sustained rate is one input word per cycle. The queue soaks up a few extra
// results; once it is full, each further extra result stalls the input when
// words come back to back. The first result word of an accepted word goes
// through the command queue and is then registered in the back end output.

module jpeg_frame_capture_deframer import jfcd_pkg::*; #(
  parameter int REGION_BYTES = 131072,
  parameter int FIRST_READ   = 2048,
  parameter int HEADER_BYTES = 11
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data
);

  logic push, q_full, q_valid, q_pop;
  cmd_t push_cmd, q_cmd;

  jfcd_front #(
    .REGION_BYTES (REGION_BYTES),
    .FIRST_READ   (FIRST_READ),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_full      (q_full),
    .push        (push),
    .cmd         (push_cmd)
  );

  jfcd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_cmd  (q_cmd)
  );

  jfcd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

[hdl/jfcd_checker.sv]
`timescale 1ns / 1ps
// jfcd_checker: port-level assertions for the deframer top level
// depends on jfcd_pkg; bound to jpeg_frame_capture_deframer

module jfcd_checker import jfcd_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result word changed");

  // ready flag closes the word group and goes to the flag byte
  a_done_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.frame_done |->
      out_item.last && out_item.write_addr == '0 && out_item.write_data == FLAG_READY)
    else $error("bad ready flag result");

  // sync error is a lone result without a write
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.sync_error |->
      out_item.last && !out_item.write_valid && !out_item.frame_done)
    else $error("bad sync error result");

  // words of one group follow back to back with the same frame count
  a_group_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !out_item.last |=>
      out_valid && out_item.frame_count == $past(out_item.frame_count))
    else $error("frame count changed inside a word group");

  // flag byte writes are only the busy or ready flag
  a_flag_write: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.write_valid && out_item.write_addr == '0 |->
      out_item.write_data == FLAG_BUSY || out_item.frame_done)
    else $error("unexpected write to flag byte");

endmodule

bind jpeg_frame_capture_deframer jfcd_checker u_jfcd_checker (.*);
